>>> rtl/plh_pkg.sv
// -----------------------------------------------------------------------------
// plh_pkg : shared types and constants for the profile lookup3 hash
// Word-group beat format, mix state bundle and the lookup3 round functions.
// -----------------------------------------------------------------------------
package plh_pkg;

   localparam int unsigned ID_W            = 16;
   localparam int unsigned WORD_W          = 32;
   localparam int unsigned IDS_PER_PROFILE = 16;
   localparam int unsigned WORD_IDX_W      = 3;

   localparam logic [WORD_W-1:0] SEED_WORD = 32'hdeadbeef;

   // word positions inside one profile where a group of words closes
   localparam logic [WORD_IDX_W-1:0] MIX_WORD_FIRST  = 3'd2;
   localparam logic [WORD_IDX_W-1:0] MIX_WORD_SECOND = 3'd5;
   localparam logic [WORD_IDX_W-1:0] WORD_LAST       =
      WORD_IDX_W'(IDS_PER_PROFILE / 2 - 1);

   typedef enum logic {
      GK_MIX,
      GK_FINAL
   } group_kind_type;

   // one beat between front and back: up to three words for a, b and c
   typedef struct packed {
      group_kind_type    kind;
      logic [WORD_W-1:0] w0;
      logic [WORD_W-1:0] w1;
      logic [WORD_W-1:0] w2;
   } group_type;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
   } abc_type;

   function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                input int unsigned k);
      return (x << k) | (x >> (WORD_W - k));
   endfunction

   // one of the six rounds of the lookup3 mix
   function automatic abc_type mix_round(input abc_type s, input logic [2:0] idx);
      abc_type r;
      r = s;
      case (idx)
         3'd0: begin
            r.a = (r.a - r.c) ^ rotl32(r.c, 4);  r.c = r.c + r.b;
         end
         3'd1: begin
            r.b = (r.b - r.a) ^ rotl32(r.a, 6);  r.a = r.a + r.c;
         end
         3'd2: begin
            r.c = (r.c - r.b) ^ rotl32(r.b, 8);  r.b = r.b + r.a;
         end
         3'd3: begin
            r.a = (r.a - r.c) ^ rotl32(r.c, 16); r.c = r.c + r.b;
         end
         3'd4: begin
            r.b = (r.b - r.a) ^ rotl32(r.a, 19); r.a = r.a + r.c;
         end
         3'd5: begin
            r.c = (r.c - r.b) ^ rotl32(r.b, 4);  r.b = r.b + r.a;
         end
         default: begin
            r = s;
         end
      endcase
      return r;
   endfunction

   // one of the seven steps of the lookup3 final
   function automatic abc_type final_step(input abc_type s, input logic [2:0] idx);
      abc_type r;
      r = s;
      case (idx)
         3'd0: r.c = (r.c ^ r.b) - rotl32(r.b, 14);
         3'd1: r.a = (r.a ^ r.c) - rotl32(r.c, 11);
         3'd2: r.b = (r.b ^ r.a) - rotl32(r.a, 25);
         3'd3: r.c = (r.c ^ r.b) - rotl32(r.b, 16);
         3'd4: r.a = (r.a ^ r.c) - rotl32(r.c, 4);
         3'd5: r.b = (r.b ^ r.a) - rotl32(r.a, 14);
         3'd6: r.c = (r.c ^ r.b) - rotl32(r.b, 24);
         default: r = s;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/profile_lookup3_hash.sv
// -----------------------------------------------------------------------------
// profile_lookup3_hash : lookup3 hash of a sixteen-id interface profile
// Front pairs ids into words, back runs the lookup3 mix and final.
// -----------------------------------------------------------------------------
// Usage
//   Input side is a queue write port: drive req_interface_id with req_push;
//   a beat is taken on a rising edge with req_push high and req_full low.
//   Sixteen beats make one profile; the first id of each pair is the low
//   half of a 32-bit word. Profiles follow one another with no gap.
//   Result side is a queue read port: rsp_profile_hash holds the oldest
//   hash while rsp_empty is low, and rsp_pop takes it.
//   Throughput: one id per cycle sustained while the result queue has room;
//   the back engine keeps up with the front and has spare cycles, as it
//   runs two lookup3 rounds per cycle on each mix or final group.
//   Latency: the hash goes via group queue, back engine and result queue.
//   Reset (synchronous, active high) reseeds a, b, c, drops any part
//   profile and empties both queues; req_full is low the cycle after.
//   Receiver stall: results wait in the result queue; once it is full the
//   back engine holds, the group queue fills and req_full rises.
// -----------------------------------------------------------------------------
module profile_lookup3_hash #(
   parameter int unsigned GROUP_QUEUE_DEPTH  = 2,
   parameter int unsigned RESULT_QUEUE_DEPTH = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [plh_pkg::ID_W-1:0]    req_interface_id,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [plh_pkg::WORD_W-1:0]  rsp_profile_hash
);
   import plh_pkg::*;

   // front to back: whole word groups
   logic              grp_push, grp_pop, grp_empty;
   group_type         grp_in, grp_out;

   // back to result queue
   logic              res_push, res_full;
   logic [WORD_W-1:0] res_data;

   plh_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_interface_id (req_interface_id),
      .grp_full         (req_full),
      .grp_push         (grp_push),
      .grp_data         (grp_in)
   );

   // group queue lets the front keep taking ids while the back mixes
   plh_queue #(
      .WIDTH ($bits(group_type)),
      .DEPTH (GROUP_QUEUE_DEPTH)
   ) u_group_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (grp_push),
      .push_data (grp_in),
      .full      (req_full),
      .pop       (grp_pop),
      .pop_data  (grp_out),
      .empty     (grp_empty)
   );

   plh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .grp_empty (grp_empty),
      .grp_data  (grp_out),
      .grp_pop   (grp_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_data  (res_data)
   );

   // result queue is the output register towards the receiver
   plh_queue #(
      .WIDTH (WORD_W),
      .DEPTH (RESULT_QUEUE_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_profile_hash),
      .empty     (rsp_empty)
   );

endmodule

>>> rtl/plh_queue.sv
// -----------------------------------------------------------------------------
// plh_queue : small register-based FIFO
// Push/full on the write side, pop/empty on the read side, head shown while
// not empty.
// -----------------------------------------------------------------------------
module plh_queue #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/plh_front.sv
// -----------------------------------------------------------------------------
// plh_front : id pairing and word grouping
// Pairs ids into words and gathers words into mix or final group beats.
// -----------------------------------------------------------------------------
module plh_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  logic [plh_pkg::ID_W-1:0]  req_interface_id,
   input  logic                      grp_full,
   output logic                      grp_push,
   output plh_pkg::group_type        grp_data
);
   import plh_pkg::*;

   localparam int unsigned POS_W = $clog2(IDS_PER_PROFILE);

   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [ID_W-1:0]       held_ff, held_in;
   logic [WORD_W-1:0]     w0_ff, w0_in;
   logic [WORD_W-1:0]     w1_ff, w1_in;
   logic                  accept;
   logic [WORD_W-1:0]     word;
   logic [WORD_IDX_W-1:0] word_idx;
   logic                  first_of_group;

   assign accept   = req_push & ~grp_full;
   assign word     = {req_interface_id, held_ff};
   assign word_idx = pos_ff[POS_W-1:1];
   assign first_of_group = (word_idx == '0)
                        || (word_idx == MIX_WORD_FIRST + 1'b1)
                        || (word_idx == MIX_WORD_SECOND + 1'b1);

   always_comb begin
      pos_in   = pos_ff;
      held_in  = held_ff;
      w0_in    = w0_ff;
      w1_in    = w1_ff;
      grp_push = 1'b0;
      grp_data = '{kind: GK_MIX, w0: w0_ff, w1: w1_ff, w2: word};
      if (accept) begin
         pos_in = pos_ff + 1'b1;
         if (!pos_ff[0]) begin
            held_in = req_interface_id;
         end else if (word_idx == WORD_LAST) begin
            grp_push = 1'b1;
            grp_data = '{kind: GK_FINAL, w0: w0_ff, w1: word, w2: '0};
         end else if (word_idx == MIX_WORD_FIRST || word_idx == MIX_WORD_SECOND) begin
            grp_push = 1'b1;
         end else if (first_of_group) begin
            w0_in = word;
         end else begin
            w1_in = word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         held_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      w0_ff <= w0_in;
      w1_ff <= w1_in;
   end

endmodule

>>> rtl/plh_back.sv
// -----------------------------------------------------------------------------
// plh_back : lookup3 mix and final engine
// Adds a group of words into a, b, c, then runs two rounds per cycle.
// -----------------------------------------------------------------------------
module plh_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        grp_empty,
   input  plh_pkg::group_type          grp_data,
   output logic                        grp_pop,
   input  logic                        res_full,
   output logic                        res_push,
   output logic [plh_pkg::WORD_W-1:0]  res_data
);
   import plh_pkg::*;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MIX,
      BK_FINAL
   } state_type;

   localparam logic [1:0] MIX_STEP_LAST   = 2'd2;
   localparam logic [1:0] FINAL_STEP_LAST = 2'd3;

   state_type  state_ff, state_in;
   logic [1:0] step_ff, step_in;
   abc_type    abc_ff, abc_in;
   abc_type    mixed, finished, final_last;

   assign mixed      = mix_round(mix_round(abc_ff, {step_ff, 1'b0}), {step_ff, 1'b1});
   assign finished   = final_step(final_step(abc_ff, {step_ff, 1'b0}), {step_ff, 1'b1});
   assign final_last = final_step(abc_ff, {step_ff, 1'b0});
   assign res_data   = final_last.c;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      abc_in   = abc_ff;
      grp_pop  = 1'b0;
      res_push = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!grp_empty) begin
               grp_pop  = 1'b1;
               step_in  = '0;
               abc_in.a = abc_ff.a + grp_data.w0;
               abc_in.b = abc_ff.b + grp_data.w1;
               if (grp_data.kind == GK_MIX) begin
                  abc_in.c = abc_ff.c + grp_data.w2;
                  state_in = BK_MIX;
               end else begin
                  state_in = BK_FINAL;
               end
            end
         end
         BK_MIX: begin
            abc_in  = mixed;
            step_in = step_ff + 1'b1;
            if (step_ff == MIX_STEP_LAST) begin
               state_in = BK_IDLE;
            end
         end
         BK_FINAL: begin
            if (step_ff != FINAL_STEP_LAST) begin
               abc_in  = finished;
               step_in = step_ff + 1'b1;
            end else if (!res_full) begin
               // last final step lands straight in the result queue; reseed
               res_push = 1'b1;
               abc_in   = '{a: SEED_WORD, b: SEED_WORD, c: SEED_WORD};
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         step_ff  <= '0;
         abc_ff   <= '{a: SEED_WORD, b: SEED_WORD, c: SEED_WORD};
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         abc_ff   <= abc_in;
      end
   end

endmodule

>>> rtl/plh_checker.sv
// -----------------------------------------------------------------------------
// plh_checker : port-level checks for the profile hash
// Reset behaviour, result hold under stall and minimum result latency.
// -----------------------------------------------------------------------------
module plh_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_full,
   input logic                        rsp_empty,
   input logic                        rsp_pop,
   input logic [plh_pkg::WORD_W-1:0]  rsp_profile_hash
);

   // reset leaves nothing to read
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // reset frees the input side at once
   a_reset_ready: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input side still full after reset");

   // an unpopped result stays and holds its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_profile_hash))
      else $error("waiting result lost or changed");

   // a hash needs the final group to pass the back engine after reset
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_empty) |-> !$past(reset) && !$past(reset, 2) && !$past(reset, 3))
      else $error("result appeared too soon after reset");

endmodule

bind profile_lookup3_hash plh_checker u_plh_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_profile_hash (rsp_profile_hash)
);

>>> tb/profile_lookup3_hash_tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// profile_lookup3_hash_tb : self-checking bench for the profile lookup3 hash
// Streams sixteen-id profiles through the queue-style ports with random gaps
// on both sides and a long result hold-off. An in-bench lookup3 predictor
// checks every profile hash in order.
// -----------------------------------------------------------------------------
module profile_lookup3_hash_tb;

   localparam int unsigned ID_BITS      = plh_pkg::ID_W;
   localparam int unsigned KEY_BITS     = plh_pkg::WORD_W;
   localparam int unsigned PROFILE_IDS  = plh_pkg::IDS_PER_PROFILE;
   localparam int unsigned CYCLE_LIMIT  = 500_000;
   localparam int unsigned LONG_STALL   = 300;  // receiver hold-off, cycles
   localparam int unsigned DRAIN_CYCLES = 20;   // extra wait once every predicted hash is checked
   localparam int unsigned RANDOM_PROFILES = 84;
   localparam int unsigned MAX_REPORTS  = 40;

   // ---------------------------------------------------------------------------
   // Clock, reset and DUT ports; every input known from time zero
   // ---------------------------------------------------------------------------
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   logic [ID_BITS-1:0]  req_interface_id = '0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   logic [KEY_BITS-1:0] rsp_profile_hash;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   profile_lookup3_hash dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_interface_id (req_interface_id),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_profile_hash (rsp_profile_hash)
   );

   // ---------------------------------------------------------------------------
   // Bookkeeping shared by the stimulus, the checker and the watchdog
   // ---------------------------------------------------------------------------
   logic [KEY_BITS-1:0] hash_expected[$];   // predicted hashes, oldest first
   int unsigned         mismatch_count = 0;
   int unsigned         ids_sent = 0;
   int unsigned         hashes_checked = 0;
   int unsigned         full_cycles = 0;    // cycles with an offer refused
   int unsigned         cycle_count = 0;
   bit                  no_idle = 1'b0;     // both sides run flat out when set
   logic                receiver_held = 1'b0;
   event                long_stall_ev;

   // ---------------------------------------------------------------------------
   // Predictor: its own a/b/c, the parked low id of a pair and the id count
   // ---------------------------------------------------------------------------
   logic [KEY_BITS-1:0] hash_a, hash_b, hash_c;
   logic [ID_BITS-1:0]  parked_low_id;
   int unsigned         ids_in_profile;

   function automatic void reseed_profile();
      hash_a         = plh_pkg::SEED_WORD;
      hash_b         = plh_pkg::SEED_WORD;
      hash_c         = plh_pkg::SEED_WORD;
      parked_low_id  = '0;
      ids_in_profile = 0;
   endfunction

   function automatic logic [KEY_BITS-1:0] rot_left(input logic [KEY_BITS-1:0] v,
                                                    input int unsigned n);
      return (v << n) | (v >> (KEY_BITS - n));
   endfunction

   // lookup3 mix, run after each full group of three words
   function automatic void stir_abc();
      hash_a -= hash_c;  hash_a ^= rot_left(hash_c, 4);   hash_c += hash_b;
      hash_b -= hash_a;  hash_b ^= rot_left(hash_a, 6);   hash_a += hash_c;
      hash_c -= hash_b;  hash_c ^= rot_left(hash_b, 8);   hash_b += hash_a;
      hash_a -= hash_c;  hash_a ^= rot_left(hash_c, 16);  hash_c += hash_b;
      hash_b -= hash_a;  hash_b ^= rot_left(hash_a, 19);  hash_a += hash_c;
      hash_c -= hash_b;  hash_c ^= rot_left(hash_b, 4);   hash_b += hash_a;
   endfunction

   // lookup3 final avalanche, run once the last word is in
   function automatic void seal_abc();
      hash_c ^= hash_b;  hash_c -= rot_left(hash_b, 14);
      hash_a ^= hash_c;  hash_a -= rot_left(hash_c, 11);
      hash_b ^= hash_a;  hash_b -= rot_left(hash_a, 25);
      hash_c ^= hash_b;  hash_c -= rot_left(hash_b, 16);
      hash_a ^= hash_c;  hash_a -= rot_left(hash_c, 4);
      hash_b ^= hash_a;  hash_b -= rot_left(hash_a, 14);
      hash_c ^= hash_b;  hash_c -= rot_left(hash_b, 24);
   endfunction

   // Takes one id; returns 1 with the profile hash when the id closes a profile.
   function automatic bit absorb_id(input logic [ID_BITS-1:0] id,
                                    output logic [KEY_BITS-1:0] key);
      logic [KEY_BITS-1:0] word;
      int unsigned         word_no;
      key = '0;
      // first id of a pair only waits for its partner
      if (ids_in_profile[0] == 1'b0) begin
         parked_low_id  = id;
         ids_in_profile = ids_in_profile + 1;
         return 1'b0;
      end
      word    = {id, parked_low_id};   // first id of the pair is the low half
      word_no = ids_in_profile / 2;
      case (word_no % 3)
         0:       hash_a += word;
         1:       hash_b += word;
         default: hash_c += word;
      endcase
      // the sixteenth id: final step, hand out c, back to the seed
      if (ids_in_profile == PROFILE_IDS - 1) begin
         seal_abc();
         key = hash_c;
         reseed_profile();
         return 1'b1;
      end
      if (word_no == plh_pkg::MIX_WORD_FIRST || word_no == plh_pkg::MIX_WORD_SECOND)
         stir_abc();
      ids_in_profile = ids_in_profile + 1;
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------------------
   // Random helpers
   // ---------------------------------------------------------------------------
   // mostly back-to-back, some short gaps, now and then a long one
   function automatic int unsigned idle_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // ids lean towards the all-zero and all-one extremes now and then
   function automatic logic [ID_BITS-1:0] pick_id();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 8)  return '0;
      if (roll < 16) return '1;
      return ID_BITS'($urandom_range(0, (1 << ID_BITS) - 1));
   endfunction

   task automatic report_mismatch(input string what, input logic [KEY_BITS-1:0] got,
                                  input logic [KEY_BITS-1:0] want);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t ns  %s: got %08h, want %08h", $time, what, got, want);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------------
   // Sender: one beat per call, entered just after a rising edge. Valid stays
   // high across back-to-back beats and is only dropped when a gap follows.
   // ---------------------------------------------------------------------------
   task automatic send_id(input logic [ID_BITS-1:0] id);
      logic [KEY_BITS-1:0] key;
      int unsigned         gap;
      req_push         <= 1'b1;
      req_interface_id <= id;
      do
         @(posedge clock);
      while (req_full);
      ids_sent++;
      if (absorb_id(id, key))
         hash_expected.push_back(key);
      gap = no_idle ? 0 : idle_gap();
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_profile();
      repeat (PROFILE_IDS) send_id(pick_id());
   endtask

   // ---------------------------------------------------------------------------
   // Receiver: checks each popped beat against the oldest prediction, then
   // picks the next pop. Sampled values are the ones from before the edge.
   // ---------------------------------------------------------------------------
   int unsigned pop_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (hash_expected.size() == 0) begin
               report_mismatch("hash with nothing expected", rsp_profile_hash, '0);
            end else begin
               if (rsp_profile_hash !== hash_expected[0])
                  report_mismatch("profile_hash", rsp_profile_hash, hash_expected[0]);
               void'(hash_expected.pop_front());
               hashes_checked++;
            end
         end
         if (receiver_held) begin
            rsp_pop <= 1'b0;
         end else if (pop_gap != 0 && !no_idle) begin
            rsp_pop <= 1'b0;
            pop_gap--;
         end else begin
            rsp_pop <= 1'b1;
            pop_gap = idle_gap();
         end
      end
   end

   // long receiver hold-off, counted here so the sender keeps pushing meanwhile
   always begin
      @(long_stall_ev);
      receiver_held <= 1'b1;
      repeat (LONG_STALL) @(posedge clock);
      receiver_held <= 1'b0;
   end

   // watchdog, plus a count of offers the block turned away
   always @(posedge clock) begin
      cycle_count++;
      if (req_push && req_full)
         full_cycles++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("cycle limit of %0d reached with %0d hashes outstanding",
                  CYCLE_LIMIT, hash_expected.size());
         $display("[profile_lookup3_hash] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------
   // One hand-built profile: both extremes in low and high halves, single
   // bits at either end, alternating patterns; its last beat closes a profile.
   task automatic test_directed_extremes();
      logic [ID_BITS-1:0] ids[PROFILE_IDS];
      ids = '{16'h0000, 16'hffff, 16'hffff, 16'h0000, 16'h0001, 16'h8000,
              16'h7fff, 16'hfffe, 16'h5555, 16'haaaa, 16'h0000, 16'h0000,
              16'hffff, 16'hffff, 16'h00ff, 16'hff00};
      foreach (ids[i]) send_id(ids[i]);
   endtask

   // profiles with no idling on either side: sustained one id per cycle
   task automatic test_back_to_back();
      no_idle = 1'b1;
      repeat (4) send_profile();
      no_idle = 1'b0;
   endtask

   // receiver stops popping; the result and group queues fill and full rises
   task automatic test_receiver_hold();
      no_idle = 1'b1;
      -> long_stall_ev;
      repeat (8) send_profile();
      no_idle = 1'b0;
   endtask

   // bulk random profiles, some run flat out and the rest with random gaps
   task automatic test_random_profiles();
      repeat (RANDOM_PROFILES) begin
         no_idle = ($urandom_range(0, 99) < 15);
         send_profile();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reseed_profile();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_back_to_back();
      test_receiver_hold();
      test_random_profiles();

      // drop valid after the last beat, then let everything drain
      req_push <= 1'b0;
      no_idle = 1'b1;
      while (hash_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Pushed %0d interface ids and checked %0d profile hashes in %0d cycles.",
               ids_sent, hashes_checked, cycle_count);
      $display("Input held off on %0d cycles; %0d mismatches.", full_cycles,
               mismatch_count);
      if (mismatch_count == 0)
         $display("[profile_lookup3_hash] OK");
      else
         $display("[profile_lookup3_hash] ERROR");
      $finish;
   end

endmodule
